// ===== src/universal_string_hash_assert.svh =====
// Assertion macros used by the checker of the string hash block.
`ifndef UNIVERSAL_STRING_HASH_ASSERT_SVH
`define UNIVERSAL_STRING_HASH_ASSERT_SVH

// same-cycle implication, sampled on clk, off while in reset
`define USH_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("string hash check failed");

// next-cycle implication, sampled on clk, off while in reset
`define USH_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("string hash check failed");

`endif

// ===== src/ush_pkg.sv =====
// Constants and controller/datapath handshake types for the string hash block.
package ush_pkg;

    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned HASH_W  = 16;
    localparam int unsigned PROD_W  = 2 * HASH_W;

    localparam logic [HASH_W-1:0] HASH_SEED       = 16'd31415;
    localparam logic [HASH_W-1:0] HASH_STEP       = 16'd27183;
    localparam logic [HASH_W-1:0] RESET_TABLE_SIZE = 16'd1021;
    localparam logic [HASH_W-1:0] MIN_TABLE_SIZE  = 16'd2;

    // one quotient bit per divider step
    localparam int unsigned DIV_STEPS = PROD_W;
    localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

    typedef struct packed {
        logic load;    // latch item and operands
        logic start;   // multiply and load dividers
        logic step;    // one divider step
        logic commit;  // write back state, post result on last
    } ush_cmd_t;

    typedef struct packed {
        logic last;      // current item ends a key
        logic out_busy;  // result slot full and not taken this cycle
    } ush_sts_t;

endpackage

// ===== src/ush_ifs.sv =====
// Valid/ready channel interfaces for key characters and bucket indexes.
interface ush_key_if;
    logic                        valid;
    logic                        ready;
    logic [ush_pkg::CHAR_W-1:0]  key_char;
    logic                        first_char;
    logic                        last_char;

    modport source (output valid, output key_char, output first_char, output last_char,
                    input ready);
    modport sink   (input valid, input key_char, input first_char, input last_char,
                    output ready);
endinterface

interface ush_hash_if;
    logic                        valid;
    logic                        ready;
    logic [ush_pkg::HASH_W-1:0]  bucket_index;

    modport source (output valid, output bucket_index, input ready);
    modport sink   (input valid, input bucket_index, output ready);
endinterface

// ===== src/ush_div.sv =====
// Bit-serial restoring remainder unit: 32-bit dividend, 16-bit divisor.
module ush_div
(
    input  logic                        clk,
    input  logic                        start,
    input  logic                        step,
    input  logic [ush_pkg::PROD_W-1:0]  dividend,
    input  logic [ush_pkg::HASH_W-1:0]  divisor,
    output logic [ush_pkg::HASH_W-1:0]  rem
);

    logic [ush_pkg::PROD_W-1:0] dvd_reg;
    logic [ush_pkg::HASH_W-1:0] dsr_reg;
    logic [ush_pkg::HASH_W-1:0] rem_reg;

    logic [ush_pkg::HASH_W:0]   shifted;
    logic [ush_pkg::HASH_W+1:0] diff;
    logic [ush_pkg::HASH_W-1:0] rem_next;

    // remainder stays below the divisor, so the shifted value fits in 17 bits
    assign shifted  = {rem_reg, dvd_reg[ush_pkg::PROD_W-1]};
    assign diff     = {1'b0, shifted} - {2'b00, dsr_reg};
    assign rem_next = diff[ush_pkg::HASH_W+1] ? shifted[ush_pkg::HASH_W-1:0]
                                              : diff[ush_pkg::HASH_W-1:0];

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
        end
        else if (step)
        begin
            dvd_reg <= {dvd_reg[ush_pkg::PROD_W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    assign rem = rem_reg;

endmodule

// ===== src/ush_dp.sv =====
// Datapath: table size register, hash state, multipliers, two remainder units, result slot.
module ush_dp
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  ush_pkg::ush_cmd_t           cmd,
    output ush_pkg::ush_sts_t           sts,
    input  logic [ush_pkg::CHAR_W-1:0]  key_char,
    input  logic                        first_char,
    input  logic                        last_char,
    input  logic                        cfg_wr_en,
    input  logic [ush_pkg::HASH_W-1:0]  cfg_wr_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [ush_pkg::HASH_W-1:0]  bucket_index
);

    logic [ush_pkg::HASH_W-1:0] table_size_reg;
    logic [ush_pkg::HASH_W-1:0] hash_reg;
    logic [ush_pkg::HASH_W-1:0] mult_reg;
    logic                       out_valid_reg;
    logic [ush_pkg::HASH_W-1:0] bucket_reg;

    logic [ush_pkg::CHAR_W-1:0] char_reg;
    logic                       last_reg;
    logic [ush_pkg::HASH_W-1:0] opa_reg;
    logic [ush_pkg::HASH_W-1:0] oph_reg;
    logic [ush_pkg::HASH_W-1:0] mod_h_reg;
    logic [ush_pkg::HASH_W-1:0] mod_m_reg;

    logic [ush_pkg::HASH_W-1:0] eff_size;
    logic [ush_pkg::PROD_W-1:0] prod_h;
    logic [ush_pkg::PROD_W-1:0] prod_m;
    logic [ush_pkg::HASH_W-1:0] rem_h;
    logic [ush_pkg::HASH_W-1:0] rem_m;

    // sizes below two act as two, keeping both moduli nonzero
    assign eff_size = (table_size_reg < ush_pkg::MIN_TABLE_SIZE) ? ush_pkg::MIN_TABLE_SIZE
                                                                 : table_size_reg;

    // max 65535*65535 + 255 still fits in 32 bits
    assign prod_h = ({{ush_pkg::HASH_W{1'b0}}, opa_reg} * {{ush_pkg::HASH_W{1'b0}}, oph_reg})
                    + {{(ush_pkg::PROD_W-ush_pkg::CHAR_W){1'b0}}, char_reg};
    assign prod_m = {{ush_pkg::HASH_W{1'b0}}, opa_reg}
                    * {{ush_pkg::HASH_W{1'b0}}, ush_pkg::HASH_STEP};

    ush_div u_div_hash
    (
        .clk      (clk),
        .start    (cmd.start),
        .step     (cmd.step),
        .dividend (prod_h),
        .divisor  (mod_h_reg),
        .rem      (rem_h)
    );

    ush_div u_div_mult
    (
        .clk      (clk),
        .start    (cmd.start),
        .step     (cmd.step),
        .dividend (prod_m),
        .divisor  (mod_m_reg),
        .rem      (rem_m)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_size_reg <= ush_pkg::RESET_TABLE_SIZE;
            hash_reg       <= '0;
            mult_reg       <= ush_pkg::HASH_SEED;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                table_size_reg <= cfg_wr_data;
            end
            if (cmd.commit)
            begin
                hash_reg <= rem_h;
                mult_reg <= rem_m;
            end
            if (cmd.commit && last_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            char_reg  <= key_char;
            last_reg  <= last_char;
            opa_reg   <= first_char ? ush_pkg::HASH_SEED : mult_reg;
            oph_reg   <= first_char ? '0 : hash_reg;
            mod_h_reg <= eff_size;
            mod_m_reg <= eff_size - 16'd1;
        end
        if (cmd.commit && last_reg)
        begin
            bucket_reg <= rem_h;
        end
    end

    assign sts.last     = last_reg;
    assign sts.out_busy = out_valid_reg && !out_ready;

    assign out_valid    = out_valid_reg;
    assign bucket_index = bucket_reg;

endmodule

// ===== src/ush_ctrl.sv =====
// Controller: sequences accept, multiply, 32 divider steps and write-back for each item.
module ush_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  ush_pkg::ush_sts_t   sts,
    output ush_pkg::ush_cmd_t   cmd
);

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_WB
    } state_t;

    state_t                    state_reg;
    state_t                    state_next;
    logic [ush_pkg::CNT_W-1:0] cnt_reg;
    logic [ush_pkg::CNT_W-1:0] cnt_next;

    localparam logic [ush_pkg::CNT_W-1:0] LAST_STEP = ush_pkg::CNT_W'(ush_pkg::DIV_STEPS - 1);

    assign in_ready   = (state_reg == ST_IDLE);
    assign cmd.load   = in_ready && in_valid;
    assign cmd.start  = (state_reg == ST_MUL);
    assign cmd.step   = (state_reg == ST_DIV);
    // a result waits here until the output slot frees
    assign cmd.commit = (state_reg == ST_WB) && !(sts.last && sts.out_busy);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP)
                begin
                    state_next = ST_WB;
                end
            end
            ST_WB:
            begin
                if (cmd.commit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// ===== src/universal_string_hash.sv =====
// Universal string hash: one key character per input item; on the character flagged last
// the bucket index (running hash mod table_size) comes out as one result item. Each
// character passes through these steps before the next is accepted: latch it, form
// the two products, 32 steps of two bit-serial remainder units running side by side
// (hash mod table_size, multiplier mod table_size-1), and write back. The result sits
// in an output register, so the next character is taken while it waits; only a second
// result finding that register still full holds up write-back. table_size is written
// through cfg_wr_en/cfg_wr_data; the user must do so only while no character is in
// flight, as the block itself does not enforce it; values below 2 act as 2.
module universal_string_hash
(
    input  logic                        clk,
    input  logic                        rst_n,
    ush_key_if.sink                     in_ch,
    ush_hash_if.source                  out_ch,
    input  logic                        cfg_wr_en,
    input  logic [ush_pkg::HASH_W-1:0]  cfg_wr_data
);

    ush_pkg::ush_cmd_t cmd;
    ush_pkg::ush_sts_t sts;

    ush_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ush_dp u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .key_char     (in_ch.key_char),
        .first_char   (in_ch.first_char),
        .last_char    (in_ch.last_char),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .out_valid    (out_ch.valid),
        .out_ready    (out_ch.ready),
        .bucket_index (out_ch.bucket_index)
    );

endmodule

// ===== src/ush_checker.sv =====
// Port-level checker for the string hash block, bound to the top level.
`include "universal_string_hash_assert.svh"

module ush_checker
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_ready,
    input  logic                        out_valid,
    input  logic                        out_ready,
    input  logic [ush_pkg::HASH_W-1:0]  bucket_index,
    input  logic                        cfg_wr_en,
    input  logic [ush_pkg::HASH_W-1:0]  cfg_wr_data
);

    logic [ush_pkg::HASH_W-1:0] ts_reg;
    logic [ush_pkg::HASH_W-1:0] eff_size;

    // shadow of the table size as seen on the config port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ts_reg <= ush_pkg::RESET_TABLE_SIZE;
        end
        else if (cfg_wr_en)
        begin
            ts_reg <= cfg_wr_data;
        end
    end

    assign eff_size = (ts_reg < ush_pkg::MIN_TABLE_SIZE) ? ush_pkg::MIN_TABLE_SIZE : ts_reg;

    `USH_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
    `USH_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(bucket_index))
    // one character at a time: busy right after taking one
    `USH_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
    `USH_ASSERT_SAME(a_bucket_range, out_valid, bucket_index < eff_size)

endmodule

bind universal_string_hash ush_checker u_ush_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .bucket_index (out_ch.bucket_index),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data)
);

// ===== test/tb.sv =====
// Testbench for universal_string_hash: random keys checked against an in-line hash predictor.
`timescale 1ns / 100ps

module tb;

    localparam int unsigned SETTLE_CYCLES = 40;      // outlasts the processing of one character
    localparam int unsigned CYCLE_LIMIT   = 1000000;
    localparam int unsigned PHASE_ITEMS   = 90;
    localparam int unsigned MAX_REPORTS   = 10;

    typedef struct packed {
        logic [ush_pkg::CHAR_W-1:0] key_char;
        logic                       first_char;
        logic                       last_char;
    } key_item_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic                       cfg_wr_en;
    logic [ush_pkg::HASH_W-1:0] cfg_wr_data;

    ush_key_if  key_ch ();
    ush_hash_if hash_ch ();

    universal_string_hash u_top
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_ch       (key_ch),
        .out_ch      (hash_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #5 clk = ~clk;

    key_item_t                  pending_chars[$];
    logic [ush_pkg::HASH_W-1:0] expected_buckets[$];

    // predictor state and its copy of the table size
    logic [ush_pkg::HASH_W-1:0] table_size_cfg = ush_pkg::RESET_TABLE_SIZE;
    logic [ush_pkg::HASH_W-1:0] run_hash = '0;
    logic [ush_pkg::HASH_W-1:0] run_mult = ush_pkg::HASH_SEED;

    key_item_t   held_item;
    bit          char_held = 1'b0;
    int unsigned send_gap = 0;
    int unsigned take_gap = 0;
    int unsigned tx_calm = 0;
    int unsigned rx_calm = 0;
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;

    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // advance the running hash by one character; queue the bucket on a last character
    function automatic void fold_char(input key_item_t it);
        longint unsigned modulus;
        longint unsigned acc_hash;
        longint unsigned acc_mult;
        modulus = 64'((table_size_cfg < ush_pkg::MIN_TABLE_SIZE) ? ush_pkg::MIN_TABLE_SIZE
                                                                  : table_size_cfg);
        if (it.first_char)
        begin
            run_hash = '0;
            run_mult = ush_pkg::HASH_SEED;
        end
        acc_mult = 64'(run_mult);
        acc_hash = 64'(run_hash);
        acc_hash = (acc_mult * acc_hash + 64'(it.key_char)) % modulus;
        acc_mult = (acc_mult * 64'(ush_pkg::HASH_STEP)) % (modulus - 1);
        run_hash = acc_hash[ush_pkg::HASH_W-1:0];
        run_mult = acc_mult[ush_pkg::HASH_W-1:0];
        if (it.last_char)
            expected_buckets.push_back(run_hash);
    endfunction

    function automatic void check_bucket(input logic [ush_pkg::HASH_W-1:0] got);
        logic [ush_pkg::HASH_W-1:0] want;
        if (expected_buckets.size() == 0)
        begin
            error_count++;
            if (error_count <= MAX_REPORTS)
                $display("%0t: bucket %0d with none expected", $time, got);
        end
        else
        begin
            want = expected_buckets.pop_front();
            if (got !== want)
            begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("%0t: bucket_index expected %0d, got %0d", $time, want, got);
            end
        end
    endfunction

    // key character driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_ch.valid      <= 1'b0;
            key_ch.key_char   <= '0;
            key_ch.first_char <= 1'b0;
            key_ch.last_char  <= 1'b0;
            char_held = 1'b0;
            send_gap = 0;
        end
        else
        begin
            if (key_ch.valid && key_ch.ready)
            begin
                fold_char(held_item);
                char_held = 1'b0;
            end
            if (!char_held)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    key_ch.valid <= 1'b0;
                end
                else if (pending_chars.size() != 0)
                begin
                    held_item = pending_chars.pop_front();
                    char_held = 1'b1;
                    key_ch.valid      <= 1'b1;
                    key_ch.key_char   <= held_item.key_char;
                    key_ch.first_char <= held_item.first_char;
                    key_ch.last_char  <= held_item.last_char;
                    if (tx_calm > 0)
                    begin
                        tx_calm--;
                        send_gap = 0;
                    end
                    else
                    begin
                        send_gap = idle_len();
                        if ($urandom_range(0, 59) == 0)
                            tx_calm = $urandom_range(20, 60);
                    end
                end
                else
                begin
                    key_ch.valid <= 1'b0;
                end
            end
        end
    end

    // bucket index monitor with random back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_ch.ready <= 1'b0;
            take_gap = 0;
        end
        else
        begin
            if (hash_ch.valid && hash_ch.ready)
            begin
                check_bucket(hash_ch.bucket_index);
                if (rx_calm > 0)
                begin
                    rx_calm--;
                    take_gap = 0;
                end
                else
                begin
                    take_gap = idle_len();
                    if ($urandom_range(0, 29) == 0)
                        rx_calm = $urandom_range(10, 30);
                end
            end
            if (take_gap > 0)
            begin
                take_gap--;
                hash_ch.ready <= 1'b0;
            end
            else
            begin
                hash_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic void push_char(input logic [ush_pkg::CHAR_W-1:0] ch, input logic first,
                                      input logic last);
        key_item_t it;
        it.key_char   = ch;
        it.first_char = first;
        it.last_char  = last;
        pending_chars.push_back(it);
    endfunction

    function automatic logic [ush_pkg::CHAR_W-1:0] rand_char();
        int unsigned r;
        if ($urandom_range(0, 19) == 0)
            return '0;
        r = $urandom_range(1, 255);
        return r[ush_pkg::CHAR_W-1:0];
    endfunction

    function automatic int unsigned key_len();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(8, 24);
        return $urandom_range(1, 6);
    endfunction

    function automatic void push_key(input int unsigned len);
        for (int unsigned i = 0; i < len; i++)
            push_char(rand_char(), i == 0, i == len - 1);
    endfunction

    task automatic wait_for_results();
        while (pending_chars.size() != 0 || char_held || expected_buckets.size() != 0)
            @(posedge clk);
    endtask

    // a character that ends no key may still be in flight after the last result
    task automatic drain_and_settle();
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_table_size(input logic [ush_pkg::HASH_W-1:0] size);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= size;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        table_size_cfg = size;
    endtask

    task automatic run_random_phase(input int unsigned n_items);
        int unsigned pushed;
        int unsigned len;
        bit          paused;
        pushed = 0;
        paused = 1'b0;
        while (pushed < n_items)
        begin
            // sender holds off mid-phase until every result is back
            if (!paused && pushed >= n_items / 2)
            begin
                wait_for_results();
                paused = 1'b1;
            end
            if ($urandom_range(0, 99) < 85)
            begin
                len = key_len();
                push_key(len);
                pushed += len;
            end
            else
            begin
                push_char(rand_char(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                pushed++;
            end
        end
    endtask

    logic [ush_pkg::HASH_W-1:0] phase_sizes[$];

    initial
    begin
        key_ch.valid      = 1'b0;
        key_ch.key_char   = '0;
        key_ch.first_char = 1'b0;
        key_ch.last_char  = 1'b0;
        hash_ch.ready     = 1'b0;
        cfg_wr_en         = 1'b0;
        cfg_wr_data       = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // no first flag straight out of reset: continues from the reset state
        push_char(8'h41, 1'b0, 1'b0);
        push_char(8'h42, 1'b0, 1'b1);
        // one-character keys at the byte extremes
        push_char(8'hFF, 1'b1, 1'b1);
        push_char(8'h00, 1'b1, 1'b1);
        push_char(8'h01, 1'b1, 1'b1);
        // zero byte inside a key does not end it
        push_char(8'h61, 1'b1, 1'b0);
        push_char(8'h00, 1'b0, 1'b0);
        push_char(8'h62, 1'b0, 1'b1);
        // first flag again mid-key restarts the hash
        push_char(8'h10, 1'b1, 1'b0);
        push_char(8'h20, 1'b1, 1'b0);
        push_char(8'h30, 1'b0, 1'b1);
        // carries on from the previous key without a first flag
        push_char(8'h7F, 1'b0, 1'b1);
        push_char(8'h80, 1'b1, 1'b0);
        push_char(8'hAA, 1'b0, 1'b0);
        push_char(8'h55, 1'b0, 1'b1);
        drain_and_settle();

        // table size changes between characters of one key
        push_char(8'h31, 1'b1, 1'b0);
        push_char(8'h32, 1'b0, 1'b0);
        drain_and_settle();
        write_table_size(16'd97);
        push_char(8'h33, 1'b0, 1'b1);
        drain_and_settle();

        phase_sizes = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd65535, 16'd65534, 16'd256};
        phase_sizes.push_back(16'($urandom_range(4, 65533)));
        phase_sizes.push_back(16'($urandom_range(4, 65533)));
        phase_sizes.push_back(ush_pkg::RESET_TABLE_SIZE);
        foreach (phase_sizes[i])
        begin
            write_table_size(phase_sizes[i]);
            run_random_phase(PHASE_ITEMS);
            drain_and_settle();
        end

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+src
src/ush_pkg.sv
src/ush_ifs.sv
src/ush_div.sv
src/ush_dp.sv
src/ush_ctrl.sv
src/universal_string_hash.sv
src/ush_checker.sv
test/tb.sv
